@@ hw/rtl/implicit_tree_preorder_walk_defines.svh @@
// Assertion macros shared by the preorder walk checker.
`ifndef IMPLICIT_TREE_PREORDER_WALK_DEFINES_SVH
`define IMPLICIT_TREE_PREORDER_WALK_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define ITPW_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define ITPW_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define ITPW_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/itpw_pkg.sv @@
// Shared types and constants for the implicit tree preorder walk.
package itpw_pkg;

  localparam int VALUE_W = 31;

  // Incoming word: one node value per array position, last flag starts the walk
  typedef struct packed {
    logic [VALUE_W-1:0] node_value;
    logic               last_value;
  } node_in_t;

  // Outgoing word: one present node in preorder, last flag on the final one
  typedef struct packed {
    logic [VALUE_W-1:0] visited_value;
    logic               last_visit;
  } node_out_t;

  // Controller phases
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } itpw_state_t;

  // Command from the walk controller to the output stage
  typedef struct packed {
    logic               push;
    logic               finish;
    logic [VALUE_W-1:0] value;
  } itpw_emit_t;

  // Status back from the output stage
  typedef struct packed {
    logic pending;
    logic out_free;
  } itpw_emit_stat_t;

endpackage

@@ hw/rtl/implicit_tree_preorder_walk.sv @@
// Top level: loads a level-order tree into a node memory and walks it in preorder.
//
//   channel  direction  handshake                word
//   node     in         node_valid / node_stall  node_word  (node_value, last_value)
//   visit    out        visit_valid / visit_stall visit_word (visited_value, last_visit)
//
// Loading takes one node word per cycle; the last flag starts the walk and stalls input.
// The walk takes two steps per candidate position (node memory read, then check),
// then a closing flush step; output stalls can hold it.
// Output stalls hold the walk only when a new visit or the walk's end finds the held one still blocked.
// Reset (synchronous) empties the tree and the output; node memory is not cleared.
module implicit_tree_preorder_walk #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                node_valid,
  output logic                node_stall,
  input  itpw_pkg::node_in_t  node_word,
  output logic                visit_valid,
  input  logic                visit_stall,
  output itpw_pkg::node_out_t visit_word
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY) + 2;

  itpw_pkg::itpw_state_t        state, state_next;
  logic [CW-1:0]                loaded_count, loaded_count_next;
  logic [PW-1:0]                walk_position, walk_position_next;
  logic [itpw_pkg::VALUE_W-1:0] node_store [CAPACITY];
  logic [itpw_pkg::VALUE_W-1:0] rd_data;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;
  logic                         mem_we;
  logic                         room;
  logic                         present;
  logic [PW-1:0]                sibling;
  itpw_pkg::itpw_emit_t         emit;
  itpw_pkg::itpw_emit_stat_t    stat;

  // Next position in preorder after a finished subtree: climb over right
  // children, then step to the right sibling. A result of 1 means the walk is over.
  function automatic logic [PW-1:0] next_sibling(input logic [PW-1:0] p);
    logic [PW:0] q;
    logic        stop;
    q    = {1'b0, p} + (PW+1)'(1);
    stop = 1'b0;
    for (int i = 0; i < PW; i++) begin
      if (!stop && !q[0]) begin
        q = q >> 1;
      end else begin
        stop = 1'b1;
      end
    end
    return q[PW-1:0];
  endfunction

  assign node_stall = (state != itpw_pkg::ST_LOAD);
  assign room       = (loaded_count < CW'(CAPACITY));
  assign wr_addr    = AW'(loaded_count);
  assign rd_addr    = AW'(walk_position - PW'(1));
  assign present    = (walk_position <= PW'(loaded_count)) && (rd_data != '0);
  assign sibling    = next_sibling(walk_position);

  // Node memory: one write port for loading, one registered read port for the walk.
  // Writes happen only while loading, so no read that the walk uses overlaps a write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_store[wr_addr] <= node_word.node_value;
    end
    rd_data <= node_store[rd_addr];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= itpw_pkg::ST_LOAD;
      loaded_count  <= '0;
      walk_position <= '0;
    end else begin
      state         <= state_next;
      loaded_count  <= loaded_count_next;
      walk_position <= walk_position_next;
    end
  end

  // Load, then read and check one candidate position at a time, then flush
  always_comb begin
    state_next         = state;
    loaded_count_next  = loaded_count;
    walk_position_next = walk_position;
    mem_we             = 1'b0;
    emit               = '0;
    case (state)
      itpw_pkg::ST_LOAD: begin
        if (node_valid) begin
          // drop words past capacity, but still honour their last flag
          if (room) begin
            mem_we            = 1'b1;
            loaded_count_next = loaded_count + CW'(1);
          end
          if (node_word.last_value) begin
            walk_position_next = PW'(1);
            state_next         = itpw_pkg::ST_READ;
          end
        end
      end
      itpw_pkg::ST_READ: begin
        state_next = itpw_pkg::ST_CHECK;
      end
      itpw_pkg::ST_CHECK: begin
        if (present) begin
          // emit and descend to the left child; hold if the output is blocked
          if (!stat.pending || stat.out_free) begin
            emit.push          = 1'b1;
            emit.value         = rd_data;
            walk_position_next = walk_position << 1;
            state_next         = itpw_pkg::ST_READ;
          end
        end else if (sibling == PW'(1)) begin
          state_next = itpw_pkg::ST_FLUSH;
        end else begin
          walk_position_next = sibling;
          state_next         = itpw_pkg::ST_READ;
        end
      end
      itpw_pkg::ST_FLUSH: begin
        // release the held visit as the final one, then start a new tree
        if (!stat.pending || stat.out_free) begin
          emit.finish        = stat.pending;
          loaded_count_next  = '0;
          walk_position_next = '0;
          state_next         = itpw_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = itpw_pkg::ST_LOAD;
      end
    endcase
  end

  itpw_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .emit        (emit),
    .stat        (stat),
    .visit_valid (visit_valid),
    .visit_stall (visit_stall),
    .visit_word  (visit_word)
  );

endmodule

@@ hw/rtl/itpw_out_stage.sv @@
// Output stage: holds one visit back until the next is known, then marks the final one.
module itpw_out_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  itpw_pkg::itpw_emit_t       emit,
  output itpw_pkg::itpw_emit_stat_t  stat,
  output logic                       visit_valid,
  input  logic                       visit_stall,
  output itpw_pkg::node_out_t        visit_word
);

  logic                         out_valid;
  itpw_pkg::node_out_t          out_word;
  logic                         pending;
  logic [itpw_pkg::VALUE_W-1:0] pend_value;
  logic                         load_out;

  // The held visit leaves once a newer one arrives or the walk ends
  assign load_out = pending && (emit.push || emit.finish);

  assign stat.pending  = pending;
  assign stat.out_free = !out_valid || !visit_stall;

  assign visit_valid = out_valid;
  assign visit_word  = out_word;

  // Control: output valid and held-visit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!visit_stall) begin
        out_valid <= 1'b0;
      end
      if (emit.push) begin
        pending <= 1'b1;
      end else if (emit.finish) begin
        pending <= 1'b0;
      end
    end
  end

  // Payload: move held value out, capture the new one
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.visited_value <= pend_value;
      out_word.last_visit    <= emit.finish;
    end
    if (emit.push) begin
      pend_value <= emit.value;
    end
  end

endmodule

@@ hw/rtl/itpw_checker.sv @@
// Port-level checker for the preorder walk, bound to the top level.
`include "implicit_tree_preorder_walk_defines.svh"

module itpw_checker (
  input logic                clk,
  input logic                rst,
  input logic                node_valid,
  input logic                node_stall,
  input itpw_pkg::node_in_t  node_word,
  input logic                visit_valid,
  input logic                visit_stall,
  input itpw_pkg::node_out_t visit_word
);

  // A last word starts the walk, so input must stall on the next cycle
  `ITPW_ASSERT_NEXT(a_last_stalls, clk, rst, node_valid && !node_stall && node_word.last_value, node_stall, "input not stalled after last word")

  // Absent nodes are never emitted
  `ITPW_ASSERT_NOW(a_no_zero_visit, clk, rst, visit_valid, visit_word.visited_value != '0, "zero node value emitted")

  // Reset empties the output
  `ITPW_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !visit_valid, "output valid after reset")

  // A stalled visit word holds
  `ITPW_ASSERT_NEXT(a_visit_hold, clk, rst, visit_valid && visit_stall, visit_valid && $stable(visit_word), "stalled visit word changed")

endmodule

bind implicit_tree_preorder_walk itpw_checker u_itpw_checker (.*);

@@ tb/tb_implicit_tree_preorder_walk.sv @@
// Self-checking testbench for the level-order tree loader and preorder walker.
module tb_implicit_tree_preorder_walk;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W      = itpw_pkg::VALUE_W;
  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 246;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 300;
  localparam int N_DIRECTED   = 24;

  // One row of the directed table: the word to send and, where it is obvious,
  // the visits it must produce (none, or a single marked one)
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               typed;
    logic               typed_one;
    logic [VALUE_W-1:0] typed_value;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // single-node trees: small, absent root, largest, unit
    '{31'h5,        1'b1, 1'b1, 1'b1, 31'h5},
    '{31'h0,        1'b1, 1'b1, 1'b0, 31'h0},
    '{31'h7fffffff, 1'b1, 1'b1, 1'b1, 31'h7fffffff},
    '{31'h1,        1'b1, 1'b1, 1'b1, 31'h1},
    // complete three-level tree
    '{31'h1,        1'b0, 1'b0, 1'b0, 31'h0},
    '{31'h2,        1'b0, 1'b0, 1'b0, 31'h0},
    '{31'h3,        1'b0, 1'b0, 1'b0, 31'h0},
    '{31'h4,        1'b0, 1'b0, 1'b0, 31'h0},
    '{31'h5,        1'b0, 1'b0, 1'b0, 31'h0},
    '{31'h6,        1'b0, 1'b0, 1'b0, 31'h0},
    '{31'h7,        1'b1, 1'b0, 1'b0, 31'h0},
    // absent left child hides its loaded children
    '{31'd10,       1'b0, 1'b0, 1'b0, 31'h0},
    '{31'd0,        1'b0, 1'b0, 1'b0, 31'h0},
    '{31'd30,       1'b0, 1'b0, 1'b0, 31'h0},
    '{31'd40,       1'b0, 1'b0, 1'b0, 31'h0},
    '{31'd50,       1'b0, 1'b0, 1'b0, 31'h0},
    '{31'd60,       1'b0, 1'b0, 1'b0, 31'h0},
    '{31'd70,       1'b1, 1'b0, 1'b0, 31'h0},
    // absent root with present children: nothing at all
    '{31'd0,        1'b0, 1'b1, 1'b0, 31'h0},
    '{31'd8,        1'b0, 1'b1, 1'b0, 31'h0},
    '{31'd9,        1'b0, 1'b1, 1'b0, 31'h0},
    '{31'd1,        1'b1, 1'b1, 1'b0, 31'h0},
    // alternating bit patterns
    '{31'h55555555, 1'b0, 1'b0, 1'b0, 31'h0},
    '{31'h2aaaaaaa, 1'b1, 1'b0, 1'b0, 31'h0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                node_valid = 1'b0;
  logic                node_stall;
  itpw_pkg::node_in_t  node_word = '0;
  logic                visit_valid;
  logic                visit_stall = 1'b0;
  itpw_pkg::node_out_t visit_word;

  implicit_tree_preorder_walk #(.CAPACITY(CAPACITY)) dut (
    .clk        (clk),
    .rst        (rst),
    .node_valid (node_valid),
    .node_stall (node_stall),
    .node_word  (node_word),
    .visit_valid(visit_valid),
    .visit_stall(visit_stall),
    .visit_word (visit_word)
  );

  always #2 clk = ~clk;

  // Shadow of the tree being loaded
  logic [VALUE_W-1:0] tree_mem [CAPACITY];
  int unsigned        tree_len = 0;

  itpw_pkg::node_out_t visit_q [$];
  itpw_pkg::node_out_t head_visit;

  int send_idle_pct  = 6;
  int recv_stall_pct = 47;
  int errors         = 0;
  int words_sent     = 0;
  int random_words   = 0;
  int trees_walked   = 0;
  int trees_overflow = 0;
  int visits_seen    = 0;
  int max_tree_visits = 0;
  int cycle_count    = 0;

  // Store one node word; on the last flag, walk the tree and return its visits
  function automatic void load_and_walk(input itpw_pkg::node_in_t w,
                                        ref itpw_pkg::node_out_t visits[$]);
    int unsigned pending [$];
    int unsigned pos;
    logic [VALUE_W-1:0] v;
    visits.delete();
    if (tree_len < CAPACITY) begin
      tree_mem[tree_len] = w.node_value;
      tree_len++;
    end else if (w.last_value) begin
      trees_overflow++;
    end
    if (!w.last_value) return;
    pending.push_back(1);
    while (pending.size() > 0) begin
      pos = pending.pop_back();
      if (pos == 0 || pos > tree_len) continue;
      v = tree_mem[pos-1];
      if (v == '0) continue;
      visits.push_back('{visited_value: v, last_visit: 1'b0});
      // right child underneath so the left subtree comes out first
      pending.push_back(2*pos + 1);
      pending.push_back(2*pos);
    end
    if (visits.size() > 0) visits[visits.size()-1].last_visit = 1'b1;
    if (visits.size() > max_tree_visits) max_tree_visits = visits.size();
    tree_len = 0;
    trees_walked++;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(3))
      0:       return {VALUE_W{1'b1}};
      1:       return VALUE_W'($urandom_range(255) + 1);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Offer one word, hold it until taken, and record what it must cause.
  // Called and returns just after a falling edge.
  task automatic send_node(input itpw_pkg::node_in_t w, input logic typed,
                           input logic typed_one, input logic [VALUE_W-1:0] typed_value);
    itpw_pkg::node_out_t visits [$];
    while ($urandom_range(99) < send_idle_pct) begin
      node_valid <= 1'b0;
      @(negedge clk);
    end
    node_valid <= 1'b1;
    node_word  <= w;
    @(posedge clk);
    while (node_stall) @(posedge clk);
    load_and_walk(w, visits);
    if (typed) begin
      visits.delete();
      if (typed_one) visits.push_back('{visited_value: typed_value, last_visit: 1'b1});
    end
    foreach (visits[i]) visit_q.push_back(visits[i]);
    words_sent++;
    @(negedge clk);
  endtask

  // Send a whole tree of len words with random content
  task automatic send_tree(input int len, input int zero_pct, input logic zero_root);
    itpw_pkg::node_in_t w;
    for (int i = 0; i < len; i++) begin
      w.last_value = (i == len - 1);
      if (i == 0 && zero_root)                  w.node_value = '0;
      else if ($urandom_range(99) < zero_pct)   w.node_value = '0;
      else                                      w.node_value = rand_value();
      send_node(w, 1'b0, 1'b0, '0);
      random_words++;
    end
  endtask

  // Hold the input idle until every expected visit has come out
  task automatic drain_visits();
    node_valid <= 1'b0;
    do @(negedge clk); while (visit_q.size() != 0);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      visit_stall <= 1'b0;
    end else begin
      visit_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each taken visit word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && visit_valid && !visit_stall) begin
      visits_seen++;
      if (visit_q.size() == 0) begin
        $display("%0t: unexpected visit word, expected none, got value %h last %b",
                 $time, visit_word.visited_value, visit_word.last_visit);
        errors++;
      end else begin
        head_visit = visit_q.pop_front();
        if (visit_word.visited_value !== head_visit.visited_value) begin
          $display("%0t: visited_value expected %h got %h",
                   $time, head_visit.visited_value, visit_word.visited_value);
          errors++;
        end
        if (visit_word.last_visit !== head_visit.last_visit) begin
          $display("%0t: last_visit expected %b got %b",
                   $time, head_visit.last_visit, visit_word.last_visit);
          errors++;
        end
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d visits outstanding", $time, visit_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int phase;
    int want_phase;
    int pick;
    itpw_pkg::node_in_t w;
    phase = 0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      w.node_value = DIRECTED[i].value;
      w.last_value = DIRECTED[i].last;
      send_node(w, DIRECTED[i].typed, DIRECTED[i].typed_one, DIRECTED[i].typed_value);
    end

    // Random trees, idling swapped in the second phase and switched off in the third
    while (random_words < RANDOM_ITEMS) begin
      want_phase = random_words * 3 / RANDOM_ITEMS;
      if (want_phase != phase) begin
        drain_visits();
        phase = want_phase;
        send_idle_pct  = (phase == 1) ? 47 : 0;
        recv_stall_pct = (phase == 1) ? 6 : 0;
        // overflow: last flag on a dropped word still starts the walk
        if (phase == 1) send_tree(CAPACITY + 3, 0, 1'b0);
        // full tree with every node present
        if (phase == 2) send_tree(CAPACITY, 0, 1'b0);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: loose words with a random flag
        w.node_value = ($urandom_range(1)) ? rand_value() : '0;
        w.last_value = 1'($urandom_range(1));
        send_node(w, 1'b0, 1'b0, '0);
        random_words++;
      end else if (pick < 82) begin
        send_tree($urandom_range(15, 1), 20, $urandom_range(99) < 10);
      end else if (pick < 96) begin
        send_tree($urandom_range(CAPACITY - 1, 16), 15, 1'b0);
      end else begin
        send_tree($urandom_range(CAPACITY + 4, CAPACITY), 5, 1'b0);
      end
    end

    // Let the last walk finish, then allow for any stray words
    drain_visits();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d node words forming %0d trees, %0d of them past capacity.",
             words_sent, trees_walked, trees_overflow);
    $display("Checked %0d visit words, at most %0d from one tree.",
             visits_seen, max_tree_visits);
    if (errors == 0 && visit_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
